[rtl/rmh_pkg.sv]
// ----------------------------------------------------------------------------
// rmh_pkg: shared constants and key tables
// Key schedule, block geometry and helper lookups for the hash engine.
// ----------------------------------------------------------------------------
package rmh_pkg;

	localparam int LANES       = 7;
	localparam int BLOCK_BYTES = 112;
	localparam int SHORT_MAX   = 16;
	localparam int BUF_WORDS   = 16;
	localparam int BYTE_ROT    = 45;

	localparam logic [63:0] KEY0 = 64'h2D358DCCAA6C78A5;
	localparam logic [63:0] KEY1 = 64'h8BB84B93962EACC9;
	localparam logic [63:0] KEY2 = 64'h4B33A62ED433D4A3;
	localparam logic [63:0] KEY3 = 64'h4D5A2DA51DE1AA47;
	localparam logic [63:0] KEY4 = 64'hA0761D6478BD642F;
	localparam logic [63:0] KEY5 = 64'hE7037ED1A0B428DB;
	localparam logic [63:0] KEY6 = 64'h90ED1765281C388C;
	localparam logic [63:0] KEY7 = 64'hAAAAAAAAAAAAAAAA;

	// lane key by lane number
	function automatic logic [63:0] lane_key(input logic [2:0] idx);
		logic [63:0] k;
		case (idx)
			3'd0: k = KEY0;
			3'd1: k = KEY1;
			3'd2: k = KEY2;
			3'd3: k = KEY3;
			3'd4: k = KEY4;
			3'd5: k = KEY5;
			3'd6: k = KEY6;
			default: k = KEY7;
		endcase
		return k;
	endfunction

	// key for the chained tail mixes
	function automatic logic [63:0] tail_key(input logic [2:0] j);
		logic [63:0] k;
		case (j)
			3'd0, 3'd1, 3'd4: k = KEY2;
			default: k = KEY1;
		endcase
		return k;
	endfunction

endpackage

[rtl/rmh_ram.sv]
// ----------------------------------------------------------------------------
// rmh_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rmh_mix.sv]
// ----------------------------------------------------------------------------
// rmh_mix: iterative 64x64 -> 128 multiplier
// Four 32x32 partial products, one per cycle, summed into a 128-bit register.
// ----------------------------------------------------------------------------
module rmh_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic        busy,
	output logic [63:0] lo,
	output logic [63:0] hi
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         run_q, pv_s1, done_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [31:0]  opa, opb;
	logic [1:0]   sh;

	// partial product select
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin opa = a_q[31:0];  opb = b_q[31:0];  sh = 2'd0; end
			2'd1: begin opa = a_q[31:0];  opb = b_q[63:32]; sh = 2'd1; end
			2'd2: begin opa = a_q[63:32]; opb = b_q[31:0];  sh = 2'd1; end
			default: begin opa = a_q[63:32]; opb = b_q[63:32]; sh = 2'd2; end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (run_q) begin
				if (cnt_q != 3'd4) begin
					pv_s1 <= 1'b1;
					cnt_q <= cnt_q + 3'd1;
				end else begin
					pv_s1  <= 1'b0;
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (run_q && cnt_q != 3'd4) begin
				prod_s1 <= opa * opb;
				sh_s1   <= sh;
			end
			if (pv_s1) begin
				acc_q <= acc_q + ({64'b0, prod_s1} << {sh_s1, 5'b0});
			end
		end
	end

	assign done = done_q;
	assign busy = run_q;
	assign lo   = acc_q[63:0];
	assign hi   = acc_q[127:64];

endmodule

[rtl/rapid_mix_hash64_engine_core.sv]
// ----------------------------------------------------------------------------
// rapid_mix_hash64_engine_core: streaming 64-bit rapidhash (compact) engine
// Packs message bytes into a 16-word window RAM, runs seven lanes per
// 112-byte block from a lane RAM, and finalizes on the last word.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall is high while an item is at work.
// Every 64x64 product goes through one shared 32x32 multiplier. An
// ordinary word passes accept, check, merge and done. The first word of a
// message adds a seed premix plus seven lane-RAM writes. A word that pushes
// the window past 112 bytes adds seven lane mixes, each with three RAM reads,
// plus a copy of the block tail. The last word adds the finalization: lane
// reads, then unaligned window reads through RD0, RD1 and RD2 (up to fourteen
// reads) and up to eight products. The digest sits in an output register, so
// the next item is taken while it waits. No clearing pass after reset.
module rapid_mix_hash64_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	input  logic [63:0] seed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_PRE     = 5'd1;
	localparam logic [4:0] S_PREW    = 5'd2;
	localparam logic [4:0] S_LINIT   = 5'd3;
	localparam logic [4:0] S_CHK     = 5'd4;
	localparam logic [4:0] S_MERGE   = 5'd5;
	localparam logic [4:0] S_AB_RX   = 5'd6;
	localparam logic [4:0] S_AB_RY   = 5'd7;
	localparam logic [4:0] S_AB_RL   = 5'd8;
	localparam logic [4:0] S_AB_MUL  = 5'd9;
	localparam logic [4:0] S_AB_WAIT = 5'd10;
	localparam logic [4:0] S_AB_C0   = 5'd11;
	localparam logic [4:0] S_AB_C1   = 5'd12;
	localparam logic [4:0] S_AB_C2   = 5'd13;
	localparam logic [4:0] S_DONE    = 5'd14;
	localparam logic [4:0] S_FSEED   = 5'd15;
	localparam logic [4:0] S_FPLAN   = 5'd16;
	localparam logic [4:0] S_RD0     = 5'd17;
	localparam logic [4:0] S_RD1     = 5'd18;
	localparam logic [4:0] S_RD2     = 5'd19;
	localparam logic [4:0] S_FSH1    = 5'd20;
	localparam logic [4:0] S_FSH2    = 5'd21;
	localparam logic [4:0] S_FLONG   = 5'd22;
	localparam logic [4:0] S_FLX     = 5'd23;
	localparam logic [4:0] S_FLY     = 5'd24;
	localparam logic [4:0] S_FLW     = 5'd25;
	localparam logic [4:0] S_FLL     = 5'd26;
	localparam logic [4:0] S_FLR     = 5'd27;
	localparam logic [4:0] S_FMUL1   = 5'd28;
	localparam logic [4:0] S_FMW1    = 5'd29;
	localparam logic [4:0] S_FMW2    = 5'd30;
	localparam logic [4:0] S_FOUT    = 5'd31;

	localparam logic [6:0] BLK   = 7'(rmh_pkg::BLOCK_BYTES);
	localparam logic [6:0] SHORT = 7'(rmh_pkg::SHORT_MAX);
	localparam logic [2:0] LAST_LANE = 3'(rmh_pkg::LANES - 1);

	logic [4:0]  state_q, ret_q, rret_q;
	logic [63:0] data_q, seed_q;
	logic [3:0]  n_q;
	logic        last_q;
	logic        inmsg_q, bd_q, pv_q;
	logic [6:0]  pend_q, rpos_q;
	logic [63:0] part_q;
	logic [2:0]  li_q, j_q;
	logic [63:0] x_q, y_q, fseed_q, w0_q, rv_q, left_q, right_q;
	logic [63:0] digest_q;
	logic        dv_q;

	logic        buf_we;
	logic [3:0]  buf_waddr, buf_raddr;
	logic [63:0] buf_wdata, buf_rdata;
	logic        lane_we;
	logic [2:0]  lane_addr;
	logic [63:0] lane_wdata, lane_rdata;

	logic        mix_start, mix_done, mix_busy;
	logic [63:0] mix_a, mix_b, mix_lo, mix_hi, mix_res;

	logic        in_acc;
	logic [3:0]  pidx, rd_w1;
	logic [63:0] nmask;
	logic [127:0] comb;
	logic [3:0]  fill;
	logic        full;
	logic [7:0]  pend_new;
	logic [63:0] w0_fw, w1_fw;
	logic [127:0] pair;
	logic [63:0] remain;
	logic [2:0]  lane_cnt;
	logic        more_tail;
	logic [7:0]  b_last, b_mid;

	rmh_ram #(.WIDTH(64), .DEPTH(rmh_pkg::BUF_WORDS)) u_buf (
		.clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
		.raddr(buf_raddr), .rdata(buf_rdata)
	);

	rmh_ram #(.WIDTH(64), .DEPTH(rmh_pkg::LANES)) u_lane (
		.clk(clk), .we(lane_we), .waddr(lane_addr), .wdata(lane_wdata),
		.raddr(lane_addr), .rdata(lane_rdata)
	);

	rmh_mix u_mix (
		.clk(clk), .arst_n(arst_n), .start(mix_start), .a(mix_a), .b(mix_b),
		.done(mix_done), .busy(mix_busy), .lo(mix_lo), .hi(mix_hi)
	);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign mix_res  = mix_lo ^ mix_hi;
	assign remain   = {57'b0, pend_q};

	// window word that holds the open partial word
	assign pidx = pend_q[6:3] + 4'd2;
	assign rd_w1 = rpos_q[6:3] + 4'd1;

	// byte packing of the latched item
	assign nmask    = n_q[3] ? '1 : ((64'd1 << {n_q[2:0], 3'b0}) - 64'd1);
	assign comb     = ({64'b0, data_q & nmask} << {pend_q[2:0], 3'b0}) | {64'b0, part_q};
	assign fill     = {1'b0, pend_q[2:0]} + n_q;
	assign full     = fill[3];
	assign pend_new = {1'b0, pend_q} + {4'b0, n_q};

	// unaligned read with forwarding of the open partial word
	assign w0_fw = (rpos_q[6:3] == pidx && pend_q[2:0] != 3'd0) ? part_q : buf_rdata;
	assign w1_fw = (rd_w1 == pidx && pend_q[2:0] != 3'd0) ? part_q : buf_rdata;
	assign pair  = {w1_fw, w0_q} >> {rpos_q[2:0], 3'b0};

	assign lane_cnt  = bd_q ? 3'(rmh_pkg::LANES) : 3'd1;
	assign more_tail = (j_q < 3'd6) && ({1'b0, pend_q} > {1'b0, j_q + 3'd1, 4'b0});
	assign b_last    = 8'(rv_q >> {pend_q[1:0] - 2'd1, 3'b0});
	assign b_mid     = 8'(rv_q >> {1'b0, pend_q[1], 3'b0});
	assign lane_addr = li_q;

	// memory ports and multiplier requests
	always_comb begin
		buf_we     = 1'b0;
		buf_waddr  = pidx;
		buf_wdata  = comb[63:0];
		buf_raddr  = rpos_q[6:3];
		lane_we    = 1'b0;
		lane_wdata = fseed_q;
		mix_start  = 1'b0;
		mix_a      = x_q ^ rmh_pkg::lane_key(li_q);
		mix_b      = y_q ^ lane_rdata;
		case (state_q)
			S_PRE: begin
				mix_start = 1'b1;
				mix_a     = seed_q ^ rmh_pkg::KEY2;
				mix_b     = rmh_pkg::KEY1;
			end
			S_LINIT: lane_we = 1'b1;
			S_MERGE: buf_we = full;
			S_AB_RX: buf_raddr = {li_q, 1'b0} + 4'd2;
			S_AB_RY: buf_raddr = {li_q, 1'b0} + 4'd3;
			S_AB_MUL: mix_start = 1'b1;
			S_AB_WAIT: begin
				lane_we    = mix_done;
				lane_wdata = mix_res;
			end
			S_AB_C0: buf_raddr = 4'd14;
			S_AB_C1: begin
				buf_we    = 1'b1;
				buf_waddr = 4'd0;
				buf_wdata = buf_rdata;
				buf_raddr = 4'd15;
			end
			S_AB_C2: begin
				buf_we    = 1'b1;
				buf_waddr = 4'd1;
				buf_wdata = buf_rdata;
			end
			S_RD1: buf_raddr = rd_w1;
			S_FLY: begin
				mix_start = 1'b1;
				mix_a     = x_q ^ rmh_pkg::tail_key(j_q);
				mix_b     = rv_q ^ fseed_q;
			end
			S_FMUL1: begin
				mix_start = 1'b1;
				mix_a     = left_q ^ rmh_pkg::KEY1;
				mix_b     = right_q ^ fseed_q;
			end
			S_FMW1: begin
				mix_start = mix_done;
				mix_a     = mix_lo ^ rmh_pkg::KEY7;
				mix_b     = mix_hi ^ rmh_pkg::KEY1 ^ remain;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inmsg_q <= 1'b0;
			pend_q  <= '0;
			bd_q    <= 1'b0;
			dv_q    <= 1'b0;
			pv_q    <= 1'b0;
			li_q    <= '0;
			j_q     <= '0;
			ret_q   <= S_IDLE;
			rret_q  <= S_IDLE;
		end else begin
			// a taken digest frees the output unless a new one loads now
			if (dv_q && !out_stall && state_q != S_FOUT) begin
				dv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= inmsg_q ? S_CHK : S_PRE;
					end
				end
				S_PRE: begin
					pend_q  <= '0;
					bd_q    <= 1'b0;
					inmsg_q <= 1'b1;
					state_q <= S_PREW;
				end
				S_PREW: begin
					if (mix_done) begin
						li_q    <= '0;
						state_q <= S_LINIT;
					end
				end
				S_LINIT: begin
					li_q <= li_q + 3'd1;
					if (li_q == LAST_LANE) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (pend_q == BLK && n_q != 4'd0) begin
						pend_q  <= '0;
						bd_q    <= 1'b1;
						li_q    <= '0;
						ret_q   <= S_MERGE;
						state_q <= S_AB_RX;
					end else begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (pend_new > {1'b0, BLK}) begin
						pend_q  <= 7'(pend_new - {1'b0, BLK});
						bd_q    <= 1'b1;
						li_q    <= '0;
						ret_q   <= S_DONE;
						state_q <= S_AB_RX;
					end else begin
						pend_q  <= pend_new[6:0];
						state_q <= S_DONE;
					end
				end
				S_AB_RX:  state_q <= S_AB_RY;
				S_AB_RY:  state_q <= S_AB_RL;
				S_AB_RL:  state_q <= S_AB_MUL;
				S_AB_MUL: state_q <= S_AB_WAIT;
				S_AB_WAIT: begin
					if (mix_done) begin
						li_q    <= li_q + 3'd1;
						state_q <= (li_q == LAST_LANE) ? S_AB_C0 : S_AB_RX;
					end
				end
				S_AB_C0: state_q <= S_AB_C1;
				S_AB_C1: state_q <= S_AB_C2;
				S_AB_C2: state_q <= ret_q;
				S_DONE: begin
					li_q    <= '0;
					pv_q    <= 1'b0;
					state_q <= last_q ? S_FSEED : S_IDLE;
				end
				S_FSEED: begin
					if (li_q != lane_cnt) begin
						li_q <= li_q + 3'd1;
						pv_q <= 1'b1;
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							state_q <= S_FPLAN;
						end
					end
				end
				S_FPLAN: begin
					j_q <= '0;
					if (!bd_q && pend_q <= SHORT) begin
						rret_q  <= S_FSH1;
						state_q <= (pend_q == 7'd0) ? S_FMUL1 : S_RD0;
					end else begin
						state_q <= S_FLONG;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= rret_q;
				S_FSH1: begin
					rret_q  <= S_FSH2;
					state_q <= (pend_q < 7'd4) ? S_FMUL1 : S_RD0;
				end
				S_FSH2: state_q <= S_FMUL1;
				S_FLONG: begin
					rret_q  <= more_tail ? S_FLX : S_FLL;
					state_q <= S_RD0;
				end
				S_FLX: begin
					rret_q  <= S_FLY;
					state_q <= S_RD0;
				end
				S_FLY: state_q <= S_FLW;
				S_FLW: begin
					if (mix_done) begin
						j_q     <= j_q + 3'd1;
						state_q <= S_FLONG;
					end
				end
				S_FLL: begin
					rret_q  <= S_FLR;
					state_q <= S_RD0;
				end
				S_FLR:   state_q <= S_FMUL1;
				S_FMUL1: state_q <= S_FMW1;
				S_FMW1: begin
					if (mix_done) begin
						state_q <= S_FMW2;
					end
				end
				S_FMW2: begin
					if (mix_done) begin
						state_q <= S_FOUT;
					end
				end
				S_FOUT: begin
					if (!dv_q || !out_stall) begin
						dv_q    <= 1'b1;
						inmsg_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					data_q <= data_word;
					n_q    <= (byte_count > 4'd8) ? 4'd8 : byte_count;
					last_q <= last_word;
					seed_q <= seed;
				end
			end
			S_PRE: part_q <= '0;
			S_PREW: begin
				if (mix_done) begin
					fseed_q <= seed_q ^ mix_res;
				end
			end
			S_MERGE: begin
				if (pend_new > {1'b0, BLK} || full) begin
					part_q <= comb[127:64];
				end else begin
					part_q <= comb[63:0];
				end
			end
			S_AB_RY: x_q <= buf_rdata;
			S_AB_RL: y_q <= buf_rdata;
			S_DONE: fseed_q <= '0;
			S_FSEED: begin
				if (pv_q) begin
					fseed_q <= fseed_q ^ lane_rdata;
				end
			end
			S_FPLAN: begin
				left_q <= '0;
				right_q <= '0;
				rpos_q <= SHORT;
			end
			S_RD1: w0_q <= w0_fw;
			S_RD2: rv_q <= pair[63:0];
			S_FSH1: begin
				if (pend_q < 7'd4) begin
					left_q  <= ({56'b0, rv_q[7:0]} << rmh_pkg::BYTE_ROT) | {56'b0, b_last};
					right_q <= {56'b0, b_mid};
				end else if (pend_q < 7'd8) begin
					left_q <= {32'b0, rv_q[31:0]};
					rpos_q <= pend_q + 7'd12;
				end else begin
					left_q <= rv_q;
					rpos_q <= pend_q + 7'd8;
				end
			end
			S_FSH2: begin
				right_q <= (pend_q < 7'd8) ? {32'b0, rv_q[31:0]} : rv_q;
				fseed_q <= fseed_q ^ remain;
			end
			S_FLONG: rpos_q <= more_tail ? {j_q + 3'd1, 4'b0} : pend_q;
			S_FLX: begin
				x_q    <= rv_q;
				rpos_q <= {j_q + 3'd1, 4'b1000};
			end
			S_FLW: begin
				if (mix_done) begin
					fseed_q <= mix_res;
				end
			end
			S_FLL: begin
				left_q <= rv_q ^ remain;
				rpos_q <= pend_q + 7'd8;
			end
			S_FLR: right_q <= rv_q;
			S_FMW2: begin
				if (mix_done) begin
					x_q <= mix_res;
				end
			end
			S_FOUT: begin
				if (!dv_q || !out_stall) begin
					digest_q <= x_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = dv_q;
	assign digest    = digest_q;

	// the pending byte count never passes one block
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= BLK)
		else $error("pending byte count above block size");

	// the shared multiplier is never restarted while it runs
	a_mix_free: assert property (@(posedge clk) disable iff (!arst_n)
		mix_start |-> !mix_busy)
		else $error("multiplier started while busy");

	// an accepted item always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("item accepted but engine stayed idle");

	// a finished digest is always presented
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOUT && (!dv_q || !out_stall)) |=> out_valid && !inmsg_q)
		else $error("digest not presented after finalization");

	// the window is only written during packing or the block copy
	a_buf_write: assert property (@(posedge clk) disable iff (!arst_n)
		buf_we |-> (state_q == S_MERGE || state_q == S_AB_C1 || state_q == S_AB_C2))
		else $error("window written outside packing or copy");

endmodule
